// ===== src/wcs_pkg.sv =====
`default_nettype none

package wcs_pkg;

   // Size of the sequence space; sends stop once next_seq reaches it.
   localparam int unsigned NUM_PACKETS = 256;

   localparam int unsigned SEQ_W = 9;
   localparam int unsigned NUM_W = 8;
   localparam int unsigned DUP_W = 3;

   localparam logic [NUM_W-1:0] THRESH_RESET = NUM_W'(16);
   localparam logic [NUM_W-1:0] WINDOW_RESET = NUM_W'(1);
   localparam logic [NUM_W-1:0] WINDOW_MAX   = NUM_W'(255);
   localparam logic [DUP_W-1:0] DUP_LIMIT    = DUP_W'(3);

   // Item kinds on the request channel.
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_ACK  = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic [NUM_W-1:0] ack_num;
   } req_payload_type;

   typedef struct packed {
      logic             send_valid;
      logic [NUM_W-1:0] send_seq;
      logic             ack_new;
      logic             fast_retransmit;
      logic [SEQ_W-1:0] window_base;
      logic [NUM_W-1:0] window_size;
      logic [NUM_W-1:0] threshold;
   } rsp_payload_type;

   // Handshake between the input register and the update engine.
   typedef struct packed {
      logic            valid;
      req_payload_type payload;
   } stage_type;

endpackage

`default_nettype wire

// ===== src/wcs_req_if.sv =====
`default_nettype none

interface wcs_req_if import wcs_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/wcs_rsp_if.sv =====
`default_nettype none

interface wcs_rsp_if import wcs_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/wcs_in_stage.sv =====
`default_nettype none

module wcs_in_stage import wcs_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   wcs_req_if.sink    req_chan,
   input  wire logic  advance,
   output stage_type  stage
);

   logic            valid_ff;
   logic            valid_in;
   req_payload_type payload_ff;
   logic            load;

   // The register may refill in the same cycle that it hands its item on.
   assign req_chan.ready = !valid_ff || advance;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = req_chan.ready ? req_chan.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= req_chan.payload;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.payload = payload_ff;

endmodule

`default_nettype wire

// ===== src/wcs_engine.sv =====
`default_nettype none

module wcs_engine import wcs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [NUM_W-1:0] csr_wdata,
   input  wire stage_type        stage,
   output logic                  advance,
   wcs_rsp_if.source             rsp_chan
);

   localparam logic [SEQ_W:0] SeqLimit = (SEQ_W+1)'(NUM_PACKETS);

   logic [SEQ_W-1:0] base_ff, base_in;
   logic [SEQ_W-1:0] next_ff, next_in;
   logic [SEQ_W-1:0] expect_ff, expect_in;
   logic [DUP_W-1:0] dup_ff, dup_in;
   logic [NUM_W-1:0] cwnd_ff, cwnd_in;
   logic [NUM_W-1:0] ssl_ff, ssl_in;

   logic             out_valid_ff, out_valid_in;
   rsp_payload_type  out_ff, out_in;

   logic             is_ack;
   logic             can_send;
   logic             matched;
   logic             rewind;
   logic [SEQ_W:0]   window_end;
   logic [SEQ_W-1:0] ack_next;
   logic [NUM_W:0]   grown;

   assign advance      = stage.valid && (!out_valid_ff || rsp_chan.ready);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   always_comb begin
      is_ack     = (stage.payload.req_type == REQ_ACK);
      window_end = {1'b0, base_ff} + {2'b00, cwnd_ff};
      can_send   = !is_ack && ({1'b0, next_ff} < SeqLimit)
                   && ({1'b0, next_ff} < window_end);
      matched    = is_ack && ({1'b0, stage.payload.ack_num} == expect_ff);
      rewind     = is_ack && !matched && (dup_ff == DUP_LIMIT - DUP_W'(1));
      ack_next   = {1'b0, stage.payload.ack_num} + SEQ_W'(1);
      grown      = (cwnd_ff < ssl_ff) ? {cwnd_ff, 1'b0} : {1'b0, cwnd_ff} + (NUM_W+1)'(1);

      base_in   = base_ff;
      next_in   = next_ff;
      expect_in = expect_ff;
      dup_in    = dup_ff;
      cwnd_in   = cwnd_ff;
      ssl_in    = ssl_ff;

      if (can_send) begin
         next_in = next_ff + SEQ_W'(1);
      end
      if (is_ack) begin
         expect_in = ack_next;
         if (matched) begin
            base_in = ack_next;
            cwnd_in = (grown > {1'b0, WINDOW_MAX}) ? WINDOW_MAX : grown[NUM_W-1:0];
            dup_in  = '0;
         end else if (dup_ff < DUP_LIMIT) begin
            dup_in = dup_ff + DUP_W'(1);
         end
         if (rewind) begin
            ssl_in  = cwnd_ff >> 1;
            cwnd_in = WINDOW_RESET;
            next_in = base_ff;
         end
      end

      out_in.send_valid      = can_send;
      out_in.send_seq        = can_send ? next_ff[NUM_W-1:0] : '0;
      out_in.ack_new         = matched;
      out_in.fast_retransmit = rewind;
      out_in.window_base     = base_in;
      out_in.window_size     = cwnd_in;
      out_in.threshold       = ssl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         next_ff      <= '0;
         expect_ff    <= '0;
         dup_ff       <= '0;
         cwnd_ff      <= WINDOW_RESET;
         ssl_ff       <= THRESH_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            ssl_ff <= csr_wdata;
         end else if (advance) begin
            ssl_ff <= ssl_in;
         end
         if (advance) begin
            base_ff   <= base_in;
            next_ff   <= next_in;
            expect_ff <= expect_in;
            dup_ff    <= dup_in;
            cwnd_ff   <= cwnd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

endmodule

`default_nettype wire

// ===== src/window_congestion_sender_core.sv =====
// A result passes through the input register and then the output register
// before it is offered on the result channel.
// One request per cycle while results drain; the update is combinational.
// Stalls on the result channel back up through the input register only.
// Reset (synchronous, active high) clears all pointers, sets the window
// to one and the slow start threshold to 16.
`default_nettype none

module window_congestion_sender_core import wcs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [NUM_W-1:0] csr_wdata,
   wcs_req_if.sink               req_chan,
   wcs_rsp_if.source             rsp_chan
);

   // The input register holds one request; the engine applies it to the
   // window state and captures the result in its output register. Because
   // the input register refills while it hands its item on, a transfer can
   // be taken every cycle as long as the result side keeps draining.
   stage_type stage;
   logic      advance;

   wcs_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .stage    (stage)
   );

   // A write to the threshold register loads the live slow start limit.
   // Writes must happen only while the block is idle; the block does not enforce
   // this, and a write takes priority over the threshold update from a request.
   wcs_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .stage     (stage),
      .advance   (advance),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
